/* design/nfsa_pkg.sv */
// ----------------------------------------------------------------------------
// nfsa_pkg - shared types and helpers for the next-fit slot allocator
// Request/result payload structs, opcode enum and the lowest-set-bit encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package nfsa_pkg;

  localparam int unsigned MapW         = 32;  // occupancy map width
  localparam int unsigned SlotW        = 5;   // slot index width
  localparam int unsigned SlotsDefault = 32;
  localparam logic [MapW-1:0] MapAll   = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_MARK    = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [SlotW-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [SlotW-1:0] slot_granted;
    logic             ok;
  } rsp_t;

  // Index of the lowest set bit: isolate it, then one-hot to binary.
  function automatic logic [SlotW-1:0] lowest_set(input logic [MapW-1:0] v);
    logic [MapW-1:0]  low;
    logic [SlotW-1:0] idx;
    low = v & (~v + MapW'(1));
    idx = '0;
    for (int i = 0; i < MapW; i++) begin
      if (low[i]) begin
        idx = idx | SlotW'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

/* design/next_fit_slot_allocator_core.sv */
// ----------------------------------------------------------------------------
// next_fit_slot_allocator_core - next-fit bitmap slot allocator
// Allocates, marks and releases slots in an occupancy map with a search hint.
// ----------------------------------------------------------------------------
// Requests pass through the input register, then the result register.
// Throughput: one request per cycle unless the result register stalls; the map
//   and hint load with the result register; back-to-back requests see new state.
// Stalls come only from the result register waiting on out_ready_i.
// Reset (rst_ni low, async): all slots free, hint zero, both stages empty.
`default_nettype none

module next_fit_slot_allocator_core #(
  parameter int unsigned SLOTS = nfsa_pkg::SlotsDefault  // 1..32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire nfsa_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output nfsa_pkg::rsp_t     out_data_o
);

  localparam int unsigned MapW  = nfsa_pkg::MapW;
  localparam int unsigned SlotW = nfsa_pkg::SlotW;
  // Only the low SLOTS bits of the map are ever live.
  localparam logic [MapW-1:0] ValidMask = MapW'((64'd1 << SLOTS) - 64'd1);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(SLOTS - 1);

  // Input register stage
  logic           req_vld_q;
  nfsa_pkg::req_t req_q;

  // Result register stage
  logic           rsp_vld_q;
  nfsa_pkg::rsp_t rsp_q, rsp_d;

  // Allocator state
  logic [MapW-1:0]  occ_q, occ_d;
  logic [SlotW-1:0] hint_q, hint_d;

  // Request moves into the result register when that register is free or drains.
  logic advance;
  assign advance    = req_vld_q && (!rsp_vld_q || out_ready_i);
  assign in_ready_o = !req_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      req_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_data_i;
    end
  end

  // Next-fit search: lowest free slot at/above the hint, else wrap to lowest free.
  logic [MapW-1:0]  vacant, above;
  logic [SlotW-1:0] start, pick;
  logic             idx_ok;

  always_comb begin
    vacant    = ~occ_q & ValidMask;
    start     = (32'(hint_q) < SLOTS) ? hint_q : '0;
    above     = vacant & (nfsa_pkg::MapAll << start);
    pick      = (|above) ? nfsa_pkg::lowest_set(above) : nfsa_pkg::lowest_set(vacant);
    idx_ok    = 32'(req_q.slot_index) < SLOTS;

    occ_d              = occ_q;
    hint_d             = hint_q;
    rsp_d.slot_granted = '0;
    rsp_d.ok           = 1'b0;

    unique case (req_q.op)
      nfsa_pkg::OP_ALLOC: begin
        if (|vacant) begin
          occ_d[pick]        = 1'b1;
          hint_d             = (pick == LastSlot) ? '0 : pick + SlotW'(1);
          rsp_d.slot_granted = pick;
          rsp_d.ok           = 1'b1;
        end
      end
      nfsa_pkg::OP_MARK: begin
        rsp_d.slot_granted = req_q.slot_index;
        if (idx_ok) begin
          occ_d[req_q.slot_index] = 1'b1;
          rsp_d.ok                = 1'b1;
        end
      end
      nfsa_pkg::OP_RELEASE: begin
        rsp_d.slot_granted = req_q.slot_index;
        if (idx_ok) begin
          occ_d[req_q.slot_index] = 1'b0;
          rsp_d.ok                = 1'b1;
        end
      end
      default: begin
        // unused opcode: no state change, failure result
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      hint_q    <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        occ_q  <= occ_d;
        hint_q <= hint_d;
      end
      if (advance) begin
        rsp_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_vld_q;
  assign out_data_o  = rsp_q;

endmodule

`default_nettype wire

/* design/nfsa_checker.sv */
// ----------------------------------------------------------------------------
// nfsa_checker - port-level checks for the next-fit slot allocator
// Watches the top-level ports only; attached by bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module nfsa_checker #(
  parameter int unsigned SLOTS = nfsa_pkg::SlotsDefault
) (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire nfsa_pkg::req_t in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire nfsa_pkg::rsp_t out_data_o
);

  // A stalled result transfer holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Input back-pressure only comes from a full result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty result register");

  // No result right out of reset.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // A slot at or above SLOTS never reports success.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (32'(out_data_o.slot_granted) >= SLOTS) |-> !out_data_o.ok)
    else $error("success reported for out-of-range slot");

  // A stalled input request keeps its valid and data until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input request changed while stalled");

endmodule

bind next_fit_slot_allocator_core nfsa_checker #(.SLOTS(SLOTS)) u_nfsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

/* tb/next_fit_slot_allocator_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// next_fit_slot_allocator_core_tb - self-checking bench for the slot allocator
// Walks a directed table, then random phases of allocate/mark/release traffic.
// Every result is checked in order against a local next-fit model or a typed row.
// ----------------------------------------------------------------------------

module next_fit_slot_allocator_core_tb;
  import nfsa_pkg::*;

  localparam int unsigned Slots         = 32;
  localparam int unsigned WatchdogLimit = 400;  // idle cycles before giving up
  localparam int unsigned DrainCycles   = 4;    // extra wait once every result is back
  localparam int unsigned NumPhases     = 12;
  localparam int unsigned PhaseItems    = 75;
  localparam int unsigned NumRows       = 22;

  // Op code 3 is not an enum member; it must come back as a failed no-op.
  localparam op_e OpUnused = op_e'(2'd3);

  // Slots that exist; bits above Slots are never set nor searched.
  localparam logic [MapW-1:0] SlotMask =
    (Slots >= MapW) ? MapAll : (MapAll >> (MapW - Slots));

  typedef enum int unsigned {
    PH_FILL,    // mostly allocates: runs the map to full and past it
    PH_CHURN,   // balanced mix of everything
    PH_PAIRS,   // free/mark a slot, then allocate: steers the hint
    PH_DRAIN    // mostly releases
  } phase_e;

  typedef enum int unsigned {
    RX_FREE,      // always ready
    RX_RANDOM,    // ready three times in four, at random
    RX_PERIODIC,  // low for three eighths of the time, periodically
    RX_LONG       // occasional long stalls
  } rx_mode_e;

  // One directed row; the expected result is used only where typed is set.
  typedef struct packed {
    op_e              op;
    logic [SlotW-1:0] idx;
    int unsigned      reps;
    bit               typed;
    logic [SlotW-1:0] granted;
    bit               ok;
  } dir_row_t;

  // Clock, reset and DUT ports.
  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;

  // Metadata that travels with the request currently offered.
  bit   row_typed;
  rsp_t row_want;

  // Local copy of the allocator state.
  logic [MapW-1:0]  occ_model;
  logic [SlotW-1:0] hint_model;

  // Results still owed by the DUT, oldest first.
  rsp_t grant_q [$];

  dir_row_t    dir_rows [NumRows];
  int unsigned err_cnt;
  int unsigned idle_cycles;
  int unsigned burst_left;
  bit          tx_gaps;
  rx_mode_e    rx_mode;
  int unsigned rx_cnt;
  int unsigned rx_hold;

  next_fit_slot_allocator_core #(
    .SLOTS(Slots)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Next-fit prediction for one request; updates the local map and hint.
  function automatic rsp_t next_fit_result(input req_t r);
    logic [MapW-1:0]  vacant;
    logic [MapW-1:0]  above;
    logic [MapW-1:0]  cand;
    logic [SlotW-1:0] start;
    logic [SlotW-1:0] pick;
    rsp_t             res;
    res  = '0;
    pick = '0;
    case (r.op)
      OP_ALLOC: begin
        vacant = ~occ_model & SlotMask;
        // Full table: nothing changes and the result stays zero.
        if (vacant != '0) begin
          start = hint_model;
          if (start >= Slots) begin
            start = '0;
          end
          above = vacant & (MapAll << start);
          // Nothing free at or above the hint: wrap to the lowest free slot.
          cand = (above != '0) ? above : vacant;
          for (int i = MapW - 1; i >= 0; i--) begin
            if (cand[i]) begin
              pick = SlotW'(i);
            end
          end
          occ_model[pick]  = 1'b1;
          hint_model       = SlotW'((pick + 1) % Slots);
          res.slot_granted = pick;
          res.ok           = 1'b1;
        end
      end
      OP_MARK, OP_RELEASE: begin
        res.slot_granted = r.slot_index;
        if (r.slot_index < Slots) begin
          occ_model[r.slot_index] = (r.op == OP_MARK);
          res.ok                  = 1'b1;
        end
      end
      default: begin
        // Unused op code: no state change, zero result.
      end
    endcase
    return res;
  endfunction

  // Random request, weighted by the kind of phase.
  function automatic req_t random_request(input phase_e kind);
    int unsigned roll;
    req_t        r;
    roll = $urandom_range(0, 99);
    r.slot_index = SlotW'($urandom);
    // Lean on the end slots now and then.
    if ($urandom_range(0, 9) == 0) begin
      r.slot_index = $urandom_range(0, 1) ? SlotW'(Slots - 1) : '0;
    end
    case (kind)
      PH_FILL:  r.op = (roll < 85) ? OP_ALLOC : (roll < 95) ? OP_RELEASE :
                       (roll < 99) ? OP_MARK : OpUnused;
      PH_DRAIN: r.op = (roll < 70) ? OP_RELEASE : (roll < 90) ? OP_ALLOC :
                       (roll < 95) ? OP_MARK : OpUnused;
      default:  r.op = (roll < 40) ? OP_ALLOC : (roll < 65) ? OP_MARK :
                       (roll < 95) ? OP_RELEASE : OpUnused;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  // Offer one request at a falling edge and hold it until the transfer.
  // In gap mode the sender idles between bursts of random length.
  task automatic send_item(input req_t r, input bit typed, input rsp_t want);
    int unsigned gap;
    if (tx_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    in_valid  <= 1'b1;
    in_data   <= r;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stop sending and hold off until every owed result has come back.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (grant_q.size() != 0);
    repeat (DrainCycles) @(negedge clk);
    burst_left = 0;
  endtask

  // Receiver: ready changes only at the falling edge, on the current pattern.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: begin
          rx_cnt = rx_cnt + 1;
          out_ready <= ((rx_cnt % 8) >= 3);
        end
        RX_LONG: begin
          if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            out_ready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            rx_hold = $urandom_range(10, 30);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
        default: out_ready <= 1'b1;
      endcase
    end
  end

  // Scoreboard: sampled at the rising edge, where both transfers happen.
  // The result side is handled first so a request never meets its own
  // expectation in the same cycle.
  always @(posedge clk) begin : scoreboard
    rsp_t want;
    rsp_t pred;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (grant_q.size() == 0) begin
          report_mismatch("unexpected result", out_data, 0);
        end else begin
          want = grant_q.pop_front();
          if (out_data.slot_granted !== want.slot_granted) begin
            report_mismatch("slot_granted", out_data.slot_granted, want.slot_granted);
          end
          if (out_data.ok !== want.ok) begin
            report_mismatch("ok", out_data.ok, want.ok);
          end
        end
      end
      if (in_valid && in_ready) begin
        // Always advance the model; typed rows override the expectation.
        pred = next_fit_result(in_data);
        grant_q.push_back(row_typed ? row_want : pred);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned n;
    phase_e      kind;
    req_t        r;

    clk        = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    row_typed  = 1'b0;
    row_want   = '0;
    occ_model  = '0;
    hint_model = '0;
    err_cnt    = 0;
    idle_cycles = 0;
    burst_left = 0;
    tx_gaps    = 1'b0;
    rx_mode    = RX_FREE;
    rx_cnt     = 0;
    rx_hold    = 0;

    // op, index, repeat, typed, granted, ok
    dir_rows = '{
      '{OP_ALLOC,   5'd0,  1,  1'b1, 5'd0,  1'b1},  // first slot after reset
      '{OP_ALLOC,   5'd31, 1,  1'b1, 5'd1,  1'b1},  // index ignored on allocate
      '{OP_MARK,    5'd31, 1,  1'b1, 5'd31, 1'b1},  // top slot
      '{OP_MARK,    5'd0,  1,  1'b1, 5'd0,  1'b1},  // already used
      '{OP_RELEASE, 5'd0,  1,  1'b1, 5'd0,  1'b1},
      '{OP_ALLOC,   5'd0,  1,  1'b0, 5'd0,  1'b0},
      '{OpUnused,   5'd31, 1,  1'b1, 5'd0,  1'b0},  // unused op code
      '{OpUnused,   5'd0,  1,  1'b1, 5'd0,  1'b0},
      '{OP_RELEASE, 5'd31, 1,  1'b1, 5'd31, 1'b1},
      '{OP_MARK,    5'd21, 1,  1'b1, 5'd21, 1'b1},
      '{OP_RELEASE, 5'd10, 1,  1'b1, 5'd10, 1'b1},
      '{OP_ALLOC,   5'd0,  32, 1'b0, 5'd0,  1'b0},  // fill, wrap, run out
      '{OP_ALLOC,   5'd31, 1,  1'b1, 5'd0,  1'b0},  // table full
      '{OP_RELEASE, 5'd5,  1,  1'b1, 5'd5,  1'b1},
      '{OP_ALLOC,   5'd0,  1,  1'b0, 5'd0,  1'b0},  // slot 5 is the only one free
      '{OP_RELEASE, 5'd31, 1,  1'b1, 5'd31, 1'b1},
      '{OP_RELEASE, 5'd0,  1,  1'b1, 5'd0,  1'b1},
      '{OP_ALLOC,   5'd0,  1,  1'b0, 5'd0,  1'b0},
      '{OP_ALLOC,   5'd0,  1,  1'b0, 5'd0,  1'b0},
      '{OP_ALLOC,   5'd0,  1,  1'b1, 5'd0,  1'b0},  // full again
      '{OP_RELEASE, 5'd31, 1,  1'b1, 5'd31, 1'b1},
      '{OP_MARK,    5'd31, 1,  1'b1, 5'd31, 1'b1}
    };

    // Hold reset, then release it on a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table: back to back, receiver always ready.
    foreach (dir_rows[i]) begin
      for (int unsigned k = 0; k < dir_rows[i].reps; k++) begin
        r.op         = dir_rows[i].op;
        r.slot_index = dir_rows[i].idx;
        send_item(r, dir_rows[i].typed, {dir_rows[i].granted, dir_rows[i].ok});
      end
    end
    pause_until_drained();

    // Random phases. Phase 0 runs with no idling on either side.
    for (int unsigned p = 0; p < NumPhases; p++) begin
      kind    = phase_e'(p % 4);
      tx_gaps = (p != 0) && ($urandom_range(0, 3) != 0);
      rx_mode = (p == 0) ? RX_FREE : rx_mode_e'($urandom_range(0, 3));
      n = 0;
      while (n < PhaseItems) begin
        if (kind == PH_PAIRS && $urandom_range(0, 4) != 0) begin
          // Free or take a slot, then allocate right behind it.
          r.op         = $urandom_range(0, 2) != 0 ? OP_RELEASE : OP_MARK;
          r.slot_index = SlotW'($urandom);
          send_item(r, 1'b0, '0);
          r.op = OP_ALLOC;
          send_item(r, 1'b0, '0);
          n += 2;
        end else begin
          send_item(random_request(kind), 1'b0, '0);
          n++;
        end
      end
      // Sender holds off now and then until the pipe is empty.
      if (p % 3 == 2) begin
        pause_until_drained();
      end
    end

    // Wait out every owed result, then the DrainCycles margin for strays.
    pause_until_drained();
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
